// File: rtl/wbps_pkg.sv
// wbps_pkg: shared types, register codes and defaults for the wildcard byte pattern search
// used by every file under rtl; depends on nothing

package wbps_pkg;

  localparam int unsigned PatternMaxDefault = 16;
  localparam int unsigned OffsetBitsDefault = 32;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned OffsetW   = 32;
  localparam int unsigned ApbDataW  = 64;
  localparam int unsigned ApbAddrW  = 6;
  localparam int unsigned LenW      = 5;

  // register index taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_PATTERN_LOW     = 3'd0,
    REG_PATTERN_HIGH    = 3'd1,
    REG_PATTERN_LENGTH  = 3'd2,
    REG_WILDCARD_BYTE   = 3'd3,
    REG_WILDCARD_ENABLE = 3'd4
  } wbps_reg_e;

  localparam logic [LenW-1:0]  PatternLengthReset = 5'd1;
  localparam logic [ByteW-1:0] WildcardByteReset  = 8'hFF;

  typedef struct packed {
    logic [ByteW-1:0] wc_byte;
    logic             wc_en;
  } wbps_wild_t;

  typedef struct packed {
    logic step;   // word accepted while search still open
    logic clear;  // word accepted carries the end flag
  } wbps_cell_ctrl_t;

endpackage

// File: rtl/wbps_if.sv
// wbps_if: valid/ready channels for input bytes and search results
// depends on wbps_pkg for field widths

interface wbps_byte_if;
  logic                         valid;
  logic                         ready;
  logic [wbps_pkg::ByteW-1:0]   data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_result_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [wbps_pkg::OffsetW-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// File: rtl/wildcard_byte_pattern_search.sv
// wildcard_byte_pattern_search: top level, cell chain, byte counter and result register
// depends on wbps_pkg, wbps_if, wbps_cell and wbps_regs
//
//   channel   dir  handshake              payload
//   byte_i    in   valid/ready            data_byte[7:0], last_byte
//   result_o  out  valid/ready            found, match_offset[31:0]
//   apb       in   psel/penable, pready=1 paddr[5:0] (8*index), pwdata/prdata[63:0]
//
// one word per cycle while input ready is high; every cell compares its pattern byte in parallel and the chain
// steps once per word, so the cycle is set by one byte compare plus the offset subtract.
// a result appears in the output register the cycle after its word is taken.
// input ready drops only while a result waits and the sink is stalled.
// reset clears the match vector, byte counter, done flag and output valid flag; found and offset are not reset.

module wildcard_byte_pattern_search #(
  parameter int unsigned PATTERN_MAX = wbps_pkg::PatternMaxDefault,
  parameter int unsigned OFFSET_BITS = wbps_pkg::OffsetBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wbps_byte_if.sink                     byte_i,
  wbps_result_if.source                 result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wbps_pkg::ApbAddrW-1:0] paddr,
  input  logic [wbps_pkg::ApbDataW-1:0] pwdata,
  output logic [wbps_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned IdxW = $clog2(PATTERN_MAX);

  logic [PATTERN_MAX-1:0][wbps_pkg::ByteW-1:0] pat_bytes;
  logic [PATTERN_MAX-1:0]                      in_use;
  logic [IdxW-1:0]                             len_m1;
  wbps_pkg::wbps_wild_t                        wild;
  wbps_pkg::wbps_cell_ctrl_t                   ctrl;

  logic [PATTERN_MAX-1:0] vec_q, vec_next, prev_bits;

  logic                   take;
  logic                   hit;
  logic                   emit;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, start_pos;
  logic                   done_q, done_d;

  logic                         out_vld_q, out_vld_d;
  logic                         found_q;
  logic [wbps_pkg::OffsetW-1:0] off_q;

  wbps_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pat_bytes_o (pat_bytes),
    .in_use_o    (in_use),
    .len_m1_o    (len_m1),
    .wild_o      (wild)
  );

  assign byte_i.ready = !out_vld_q || result_o.ready;
  assign take         = byte_i.valid && byte_i.ready;

  assign ctrl.step  = take && !done_q;
  assign ctrl.clear = take && byte_i.last_byte;

  // cell 0 always sees a match-start token from the left
  assign prev_bits = {vec_q[PATTERN_MAX-2:0], 1'b1};

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    wbps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .wild_i      (wild),
      .pat_byte_i  (pat_bytes[g]),
      .data_byte_i (byte_i.data_byte),
      .in_use_i    (in_use[g]),
      .prev_bit_i  (prev_bits[g]),
      .next_bit_o  (vec_next[g]),
      .bit_o       (vec_q[g])
    );
  end

  assign hit       = vec_next[len_m1];
  assign start_pos = pos_q - OFFSET_BITS'(len_m1);
  assign emit      = ctrl.step && (hit || byte_i.last_byte);

  always_comb begin
    pos_d  = pos_q;
    done_d = done_q;
    if (take) begin
      pos_d = pos_q + OFFSET_BITS'(1);
      if (ctrl.step && hit) begin
        done_d = 1'b1;
      end
      if (byte_i.last_byte) begin
        pos_d  = '0;
        done_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      done_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      done_q    <= done_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q <= hit;
      off_q   <= hit ? wbps_pkg::OffsetW'(start_pos) : '0;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.found        = found_q;
  assign result_o.match_offset = off_q;

endmodule

// File: rtl/wbps_cell.sv
// wbps_cell: one match cell, holds one bit of the shift-and vector
// depends on wbps_pkg; takes the match bit of its left neighbor on each word taken while the search is open

module wbps_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbps_pkg::wbps_cell_ctrl_t  ctrl_i,
  input  wbps_pkg::wbps_wild_t       wild_i,
  input  logic [wbps_pkg::ByteW-1:0] pat_byte_i,
  input  logic [wbps_pkg::ByteW-1:0] data_byte_i,
  input  logic                       in_use_i,
  input  logic                       prev_bit_i,
  output logic                       next_bit_o,
  output logic                       bit_o
);

  logic bit_q, bit_d;
  logic byte_hit;

  assign byte_hit = (pat_byte_i == data_byte_i) ||
                    (wild_i.wc_en && (pat_byte_i == wild_i.wc_byte));

  assign next_bit_o = prev_bit_i & byte_hit & in_use_i;

  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctrl_i.step) begin
      bit_d = next_bit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

// File: rtl/wbps_regs.sv
// wbps_regs: apb configuration registers and derived pattern view
// depends on wbps_pkg; feeds pattern bytes, used length and wildcard setup to the cells

module wbps_regs #(
  parameter int unsigned PATTERN_MAX = wbps_pkg::PatternMaxDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [wbps_pkg::ApbAddrW-1:0]          paddr,
  input  logic [wbps_pkg::ApbDataW-1:0]          pwdata,
  output logic [wbps_pkg::ApbDataW-1:0]          prdata,
  output logic                                   pready,
  output logic [PATTERN_MAX-1:0][wbps_pkg::ByteW-1:0] pat_bytes_o,
  output logic [PATTERN_MAX-1:0]                 in_use_o,
  output logic [$clog2(PATTERN_MAX)-1:0]         len_m1_o,
  output wbps_pkg::wbps_wild_t                   wild_o
);

  localparam int unsigned IdxW = $clog2(PATTERN_MAX);

  logic [63:0]                   pat_lo_q, pat_hi_q;
  logic [wbps_pkg::LenW-1:0]     pat_len_q;
  logic [wbps_pkg::ByteW-1:0]    wc_byte_q;
  logic                          wc_en_q;
  logic                          wr_en;
  wbps_pkg::wbps_reg_e           reg_sel;
  logic [127:0]                  pat_all;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = wbps_pkg::wbps_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= wbps_pkg::PatternLengthReset;
      wc_byte_q <= wbps_pkg::WildcardByteReset;
      wc_en_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        wbps_pkg::REG_PATTERN_LOW:     pat_lo_q  <= pwdata;
        wbps_pkg::REG_PATTERN_HIGH:    pat_hi_q  <= pwdata;
        wbps_pkg::REG_PATTERN_LENGTH:  pat_len_q <= pwdata[wbps_pkg::LenW-1:0];
        wbps_pkg::REG_WILDCARD_BYTE:   wc_byte_q <= pwdata[wbps_pkg::ByteW-1:0];
        wbps_pkg::REG_WILDCARD_ENABLE: wc_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      wbps_pkg::REG_PATTERN_LOW:     prdata = pat_lo_q;
      wbps_pkg::REG_PATTERN_HIGH:    prdata = pat_hi_q;
      wbps_pkg::REG_PATTERN_LENGTH:  prdata = 64'(pat_len_q);
      wbps_pkg::REG_WILDCARD_BYTE:   prdata = 64'(wc_byte_q);
      wbps_pkg::REG_WILDCARD_ENABLE: prdata = 64'(wc_en_q);
      default:                       prdata = '0;
    endcase
  end

  // length zero acts as one, above the cell count clamps to the last cell
  always_comb begin
    if (pat_len_q == '0) begin
      len_m1_o = '0;
    end else if (pat_len_q > wbps_pkg::LenW'(PATTERN_MAX)) begin
      len_m1_o = IdxW'(PATTERN_MAX - 1);
    end else begin
      len_m1_o = IdxW'(pat_len_q - 5'd1);
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_bytes_o[i] = pat_all[8*i +: 8];
      in_use_o[i]    = (IdxW'(i) <= len_m1_o);
    end
  end

  assign wild_o.wc_byte = wc_byte_q;
  assign wild_o.wc_en   = wc_en_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: streams byte regions and register settings into wildcard_byte_pattern_search
// and checks every search report against an in-bench first-match predictor
// depends on wbps_pkg, wbps_if and the rtl top level

module testbench;

  localparam int unsigned PatMax      = wbps_pkg::PatternMaxDefault;
  localparam int unsigned RandomWords = 2000;
  // register indexes with nothing behind them
  localparam logic [2:0] RegSpareA = 3'd5;
  localparam logic [2:0] RegSpareB = 3'd7;

  typedef struct packed {
    logic                         found;
    logic [wbps_pkg::OffsetW-1:0] offset;
  } search_report_t;

  typedef enum logic { ROW_WRITE, ROW_WORD } row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [2:0]                    reg_idx;
    logic [wbps_pkg::ApbDataW-1:0] value;
    logic [wbps_pkg::ByteW-1:0]    data;
    logic                          last;
    bit                            typed;
    bit                            has_rep;
    search_report_t                rep;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [wbps_pkg::ApbAddrW-1:0] paddr;
  logic [wbps_pkg::ApbDataW-1:0] pwdata;
  logic [wbps_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  wbps_byte_if   byte_ch ();
  wbps_result_if res_ch ();

  wildcard_byte_pattern_search uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (res_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register mirror
  logic [wbps_pkg::ApbDataW-1:0] cfg_pat_lo = '0;
  logic [wbps_pkg::ApbDataW-1:0] cfg_pat_hi = '0;
  logic [wbps_pkg::LenW-1:0]     cfg_len    = wbps_pkg::PatternLengthReset;
  logic [wbps_pkg::ByteW-1:0]    cfg_wc     = wbps_pkg::WildcardByteReset;
  logic                          cfg_wc_en  = 1'b0;

  // search state
  logic [PatMax-1:0]            prefix_hits = '0;
  logic [wbps_pkg::OffsetW-1:0] byte_pos    = '0;
  bit                           region_done = 1'b0;

  search_report_t awaited_reports[$];
  plan_row_t      directed_rows[$];

  int unsigned words_sent       = 0;
  int unsigned regions_sent     = 0;
  int unsigned reports_seen     = 0;
  int unsigned found_seen       = 0;
  int unsigned reg_writes       = 0;
  int unsigned mismatch_count   = 0;
  int unsigned sink_hold_cycles = 0;
  bit          sender_quiet     = 1'b0;
  bit          sink_quiet       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int unsigned active_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > PatMax) return PatMax;
    return cfg_len;
  endfunction

  function automatic logic [wbps_pkg::ByteW-1:0] pattern_at(input int unsigned i);
    int unsigned k;
    k = i & 15;
    if (k < 8) return cfg_pat_lo[8*k +: 8];
    return cfg_pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic void apply_write(input logic [2:0] idx,
                                      input logic [wbps_pkg::ApbDataW-1:0] value);
    case (idx)
      wbps_pkg::REG_PATTERN_LOW:     cfg_pat_lo = value;
      wbps_pkg::REG_PATTERN_HIGH:    cfg_pat_hi = value;
      wbps_pkg::REG_PATTERN_LENGTH:  cfg_len    = value[wbps_pkg::LenW-1:0];
      wbps_pkg::REG_WILDCARD_BYTE:   cfg_wc     = value[wbps_pkg::ByteW-1:0];
      wbps_pkg::REG_WILDCARD_ENABLE: cfg_wc_en  = value[0];
      default: ;
    endcase
  endfunction

  // shift-and step over one byte; at most one report per word
  function automatic void search_step(input logic [wbps_pkg::ByteW-1:0] data,
                                      input logic last,
                                      output bit has_rep, output search_report_t rep);
    int unsigned                n;
    int unsigned                i;
    logic [PatMax-1:0]          hits;
    logic [wbps_pkg::ByteW-1:0] pb;
    has_rep = 1'b0;
    rep     = '0;
    if (!region_done) begin
      n    = active_len();
      hits = '0;
      for (i = 0; i < n; i++) begin
        pb      = pattern_at(i);
        hits[i] = (pb == data) || (cfg_wc_en && pb == cfg_wc);
      end
      prefix_hits = {prefix_hits[PatMax-2:0], 1'b1} & hits;
      if (prefix_hits[n-1]) begin
        has_rep     = 1'b1;
        rep.found   = 1'b1;
        rep.offset  = byte_pos - wbps_pkg::OffsetW'(n - 1);
        region_done = 1'b1;
      end else if (last) begin
        has_rep = 1'b1;
      end
    end
    byte_pos = byte_pos + 1'b1;
    if (last) begin
      prefix_hits = '0;
      byte_pos    = '0;
      region_done = 1'b0;
    end
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_write(input logic [2:0] idx,
                                    input logic [wbps_pkg::ApbDataW-1:0] value);
    plan_row_t row;
    row         = '{kind: ROW_WRITE, default: '0};
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.value   = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [wbps_pkg::ByteW-1:0] data, input logic last,
                                    input bit has_rep, input logic found,
                                    input logic [wbps_pkg::OffsetW-1:0] offset);
    plan_row_t row;
    row            = '{kind: ROW_WORD, default: '0};
    row.kind       = ROW_WORD;
    row.data       = data;
    row.last       = last;
    row.typed      = 1'b1;
    row.has_rep    = has_rep;
    row.rep.found  = found;
    row.rep.offset = offset;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_word(input logic [wbps_pkg::ByteW-1:0] data, input logic last);
    plan_row_t row;
    row      = '{kind: ROW_WORD, default: '0};
    row.kind = ROW_WORD;
    row.data = data;
    row.last = last;
    directed_rows.push_back(row);
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [wbps_pkg::ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_write(idx, value);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_reports.size() != 0) @(posedge clk_i);
    // a word without a report may still sit in the pipe
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_word(input logic [wbps_pkg::ByteW-1:0] data, input logic last,
                           output bit has_rep, output search_report_t rep);
    int unsigned gap;
    gap = sender_quiet ? 0 : idle_gap();
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= data;
    byte_ch.last_byte <= last;
    do @(posedge clk_i); while (!byte_ch.ready);
    search_step(data, last, has_rep, rep);
    words_sent++;
    if (last) regions_sent++;
  endtask

  task automatic run_region(input int unsigned max_len);
    logic [wbps_pkg::ByteW-1:0] region_bytes[$];
    logic [wbps_pkg::ByteW-1:0] b;
    int unsigned                n, rlen, mode, plant_at, k;
    bit                         has_rep;
    search_report_t             rep;
    n    = active_len();
    mode = $urandom_range(0, 99);
    rlen = $urandom_range(1, max_len);
    // most regions carry a copy of the pattern, some of them with one bit spoiled
    if (mode < 75 && rlen < n) rlen = n + $urandom_range(0, 3);
    for (k = 0; k < rlen; k++) begin
      if (mode % 2 == 0) begin
        region_bytes.push_back(pattern_at($urandom_range(0, n - 1)));
      end else begin
        region_bytes.push_back(wbps_pkg::ByteW'($urandom()));
      end
    end
    if (mode < 75) begin
      plant_at = $urandom_range(0, rlen - n);
      for (k = 0; k < n; k++) begin
        b = pattern_at(k);
        if (cfg_wc_en && b == cfg_wc) b = wbps_pkg::ByteW'($urandom());
        region_bytes[plant_at + k] = b;
      end
      if (mode < 20) begin
        k = plant_at + $urandom_range(0, n - 1);
        region_bytes[k] = region_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (k = 0; k < rlen; k++) begin
      send_word(region_bytes[k], k == rlen - 1, has_rep, rep);
      if (has_rep) awaited_reports.push_back(rep);
    end
  endtask

  task automatic choose_setting();
    logic [wbps_pkg::ApbDataW-1:0] lo, hi, v;
    logic [wbps_pkg::ByteW-1:0]    wc;
    logic [wbps_pkg::LenW-1:0]     len;
    int unsigned                   r, k, j;
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    r  = $urandom_range(0, 9);
    if (r == 0) begin
      lo = '0;
      hi = '0;
    end else if (r == 1) begin
      lo = '1;
      hi = '1;
    end else if (r < 5) begin
      // small alphabet so that partial matches overlap
      for (k = 0; k < 8; k++) begin
        lo[8*k +: 8] = 8'h41 + wbps_pkg::ByteW'($urandom_range(0, 2));
        hi[8*k +: 8] = 8'h41 + wbps_pkg::ByteW'($urandom_range(0, 2));
      end
    end
    case ($urandom_range(0, 9))
      0:       len = 5'd1;
      1:       len = 5'd16;
      2:       len = 5'd0;
      3:       len = wbps_pkg::LenW'($urandom_range(17, 31));
      default: len = wbps_pkg::LenW'($urandom_range(2, 15));
    endcase
    r = $urandom_range(0, 3);
    if (r == 0) wc = 8'h00;
    else if (r == 1) wc = 8'hFF;
    else wc = wbps_pkg::ByteW'($urandom());
    r = $urandom_range(0, 3);
    for (j = 0; j < r; j++) begin
      k = $urandom_range(0, 15);
      if (k < 8) lo[8*k +: 8] = wc;
      else hi[8*(k-8) +: 8] = wc;
    end
    apb_write(wbps_pkg::REG_PATTERN_LOW, lo);
    apb_write(wbps_pkg::REG_PATTERN_HIGH, hi);
    // upper bits carry noise, only the register width may stick
    v = {$urandom(), $urandom()};
    v[wbps_pkg::LenW-1:0] = len;
    apb_write(wbps_pkg::REG_PATTERN_LENGTH, v);
    v = {$urandom(), $urandom()};
    v[wbps_pkg::ByteW-1:0] = wc;
    apb_write(wbps_pkg::REG_WILDCARD_BYTE, v);
    v = {$urandom(), $urandom()};
    v[0] = 1'($urandom_range(0, 1));
    apb_write(wbps_pkg::REG_WILDCARD_ENABLE, v);
    if ($urandom_range(0, 3) == 0) begin
      apb_write($urandom_range(0, 1) ? RegSpareA : RegSpareB, {$urandom(), $urandom()});
    end
  endtask

  always @(posedge clk_i) begin : check_reports
    search_report_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      reports_seen++;
      if (res_ch.found) found_seen++;
      if (awaited_reports.size() == 0) begin
        flag_error($sformatf("report with none pending: found=%0b offset=%0d",
                             res_ch.found, res_ch.match_offset));
      end else begin
        want = awaited_reports.pop_front();
        if (res_ch.found !== want.found) begin
          flag_error($sformatf("found: expected %0b, got %0b", want.found, res_ch.found));
        end
        if (res_ch.match_offset !== want.offset) begin
          flag_error($sformatf("match_offset: expected %0d, got %0d",
                               want.offset, res_ch.match_offset));
        end
      end
    end
  end

  initial begin : drive_result_ready
    int unsigned hold, run, gap;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles != 0) begin
        // long stall: the result register fills and the byte input backs up
        hold             = sink_hold_cycles;
        sink_hold_cycles = 0;
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else if (sink_quiet) begin
        res_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        run = $urandom_range(1, 12);
        res_ch.ready <= 1'b1;
        repeat (run) @(posedge clk_i);
        gap = idle_gap();
        if (gap != 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned    ph, phase_goal, random_goal, wait_cycles;
    bit             has_rep;
    search_report_t rep;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset setting: the pattern is a single zero byte
    add_typed(8'h00, 1'b0, 1'b1, 1'b1, 32'd0);
    add_typed(8'hFF, 1'b1, 1'b0, 1'b0, 32'd0);  // after a match only the end flag counts
    add_typed(8'h12, 1'b0, 1'b0, 1'b0, 32'd0);
    add_typed(8'hFF, 1'b1, 1'b1, 1'b0, 32'd0);  // region ends without a match
    add_typed(8'h34, 1'b0, 1'b0, 1'b0, 32'd0);
    add_typed(8'h00, 1'b1, 1'b1, 1'b1, 32'd1);  // match on the final byte
    // three-byte pattern with the middle byte as wildcard
    add_write(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_00CC_BBAA);
    add_write(wbps_pkg::REG_PATTERN_LENGTH, 64'd3);
    add_write(wbps_pkg::REG_WILDCARD_BYTE, 64'hBB);
    add_write(wbps_pkg::REG_WILDCARD_ENABLE, 64'd1);
    add_word(8'hAA, 1'b0);
    add_word(8'h55, 1'b0);
    add_word(8'hCC, 1'b0);
    add_word(8'h00, 1'b1);
    add_word(8'hAA, 1'b0);
    add_word(8'hAA, 1'b0);
    add_word(8'h77, 1'b0);
    add_word(8'hCC, 1'b1);
    add_write(wbps_pkg::REG_WILDCARD_ENABLE, 64'd0);
    add_word(8'hAA, 1'b0);
    add_word(8'h55, 1'b0);
    add_word(8'hCC, 1'b1);
    // zero length behaves as one
    add_write(wbps_pkg::REG_PATTERN_LENGTH, 64'd0);
    add_word(8'hAA, 1'b1);
    add_write(RegSpareB, '1);
    // oversized length clamps to the full sixteen bytes
    add_write(wbps_pkg::REG_PATTERN_LENGTH, '1);
    add_write(wbps_pkg::REG_PATTERN_LOW, '1);
    add_write(wbps_pkg::REG_PATTERN_HIGH, '1);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b1);

    foreach (directed_rows[row]) begin
      if (directed_rows[row].kind == ROW_WRITE) begin
        wait_idle();
        apb_write(directed_rows[row].reg_idx, directed_rows[row].value);
      end else begin
        send_word(directed_rows[row].data, directed_rows[row].last, has_rep, rep);
        if (directed_rows[row].typed) begin
          if (directed_rows[row].has_rep) awaited_reports.push_back(directed_rows[row].rep);
        end else if (has_rep) begin
          awaited_reports.push_back(rep);
        end
      end
    end

    random_goal = words_sent + RandomWords;
    ph = 0;
    while (words_sent < random_goal) begin
      wait_idle();
      choose_setting();
      sender_quiet = (ph % 5 == 4) || (ph == 2);
      sink_quiet   = (ph % 5 == 4);
      if (ph == 2) sink_hold_cycles = 400;
      phase_goal = words_sent + $urandom_range(60, 180);
      while (words_sent < phase_goal) begin
        if (ph == 2) run_region(4);
        else if ($urandom_range(0, 9) == 0) run_region(300);
        else run_region(40);
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
      ph++;
    end
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;

    byte_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (awaited_reports.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (awaited_reports.size() != 0) begin
      flag_error($sformatf("%0d reports never arrived", awaited_reports.size()));
    end

    $display("searched %0d bytes in %0d regions across %0d register writes",
             words_sent, regions_sent, reg_writes);
    $display("checked %0d reports, %0d of them matches, %0d mismatches",
             reports_seen, found_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : run_limit
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
